[src/zsce_pkg.sv]
// ----------------------------------------------------------------------------
// zsce_pkg
// Shared types and constants for the zoomed sprite chunk expander: map
// geometry, field codes, controller states and controller/datapath structs.
// ----------------------------------------------------------------------------
package zsce_pkg;

  // Chunk map geometry (depth is a power of two, 64K words)
  localparam int MAP_AW    = 16;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  localparam int MAP_W     = 16;

  // Full lookup address is {tile, row, col}: 13 + 3 + 2 bits
  localparam int TILE_W    = 13;
  localparam int LOOKUP_W  = TILE_W + 5;
  localparam int ADDR_W    = (MAP_AW > LOOKUP_W) ? MAP_AW : LOOKUP_W;

  // Chunk grid
  localparam int CHUNKS_PER_SPRITE = 32;
  localparam int CHUNK_W           = $clog2(CHUNKS_PER_SPRITE);
  localparam int CNT_W             = CHUNK_W + 1;

  // Opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  // Configuration register indexes
  localparam int   CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_MASK = 1'b1;
  localparam logic [4:0]  Y_OFFSET_RESET  = 5'd3;
  localparam logic [15:0] CODE_MASK_RESET = 16'hffff;

  // Chunk code that marks an empty chunk
  localparam logic [15:0] CODE_EMPTY = 16'hffff;

  // Coordinate wrap: values past the right/bottom limit wrap negative
  localparam logic [8:0]         X_WRAP_LIMIT = 9'd320;
  localparam logic signed [10:0] Y_WRAP_LIMIT = 11'sd320;
  localparam logic [9:0]         X_WRAP_SPAN  = 10'd512;
  localparam logic signed [10:0] Y_WRAP_SPAN  = 11'sd512;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } zsce_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic               map_write;   // write one map word from the input
    logic               load_entry;  // capture a sprite entry
    logic               issue;       // read the map for chunk 'chunk'
    logic [CHUNK_W-1:0] chunk;
    logic               pend_load;   // read stage -> pending word
    logic               out_load;    // pending word -> output register
    logic               out_last;    // mark the loaded output word as last
  } zsce_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic tile_zero;  // incoming entry has tile number 0
    logic code_ok;    // chunk in read stage is not empty
  } zsce_status_t;

endpackage

[src/zsce_ram.sv]
// ----------------------------------------------------------------------------
// zsce_ram
// Generic single-port RAM with registered read; read data holds while no
// read is enabled.
// ----------------------------------------------------------------------------
module zsce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/zsce_datapath.sv]
// ----------------------------------------------------------------------------
// zsce_datapath
// Entry and config registers, chunk map RAM, chunk geometry, pending word
// and output register of the chunk expander.
// ----------------------------------------------------------------------------
module zsce_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  zsce_pkg::zsce_cmd_t        cmd,
  output zsce_pkg::zsce_status_t     status,
  // configuration
  input  logic                       cfg_write,
  input  logic [zsce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                cfg_data,
  // input word fields
  input  logic [15:0]                map_address,
  input  logic [15:0]                map_word,
  input  logic [15:0]                entry_word0,
  input  logic [15:0]                entry_word1,
  input  logic [15:0]                entry_word2,
  input  logic [15:0]                entry_word3,
  // output word fields
  output logic [15:0]                tile_code,
  output logic [7:0]                 palette,
  output logic                       flip_horizontal,
  output logic                       flip_vertical,
  output logic signed [9:0]          pos_x,
  output logic signed [9:0]          pos_y,
  output logic [17:0]                zoom_x,
  output logic [17:0]                zoom_y,
  output logic                       priority_res,
  output logic [4:0]                 chunk_index,
  output logic                       last
);

  import zsce_pkg::*;

  // Config registers
  logic [4:0]  y_offset;
  logic [15:0] code_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_offset  <= Y_OFFSET_RESET;
      code_mask <= CODE_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_Y_OFFSET:  y_offset  <= cfg_data[4:0];
        CFG_CODE_MASK: code_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry decode and coordinate wrap
  logic [8:0]         x_raw;
  logic [9:0]         x_adj;
  logic signed [10:0] y_sum;
  logic signed [10:0] y_wrap;

  always_comb begin
    x_raw  = entry_word1[8:0];
    x_adj  = (x_raw > X_WRAP_LIMIT) ? ({1'b0, x_raw} - X_WRAP_SPAN) : {1'b0, x_raw};
    y_sum  = $signed({2'b00, entry_word0[8:0]}) + $signed({{6{y_offset[4]}}, y_offset});
    y_wrap = (y_sum > Y_WRAP_LIMIT) ? (y_sum - Y_WRAP_SPAN) : y_sum;
  end

  assign status.tile_zero = (entry_word3[TILE_W-1:0] == '0);

  // Sprite entry registers
  logic [TILE_W-1:0] ent_tile;
  logic [7:0]        ent_palette;
  logic              ent_flipx;
  logic              ent_flipy;
  logic              ent_prio;
  logic [9:0]        ent_x;
  logic [9:0]        ent_y;
  logic [7:0]        ent_zoomx;
  logic [7:0]        ent_zoomy;

  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      ent_tile    <= entry_word3[TILE_W-1:0];
      ent_palette <= entry_word2[15:8];
      ent_flipx   <= entry_word1[14];
      ent_flipy   <= entry_word3[15];
      ent_prio    <= entry_word1[15];
      ent_x       <= x_adj;
      ent_y       <= y_wrap[9:0];
      ent_zoomx   <= {1'b0, entry_word2[6:0]} + 8'd1;
      ent_zoomy   <= {1'b0, entry_word0[15:9]} + 8'd1;
    end
  end

  // Map address: flipped grid position under the tile base
  logic [1:0]        col;
  logic [2:0]        row;
  logic [ADDR_W-1:0] lookup_full;
  logic [ADDR_W-1:0] load_full;
  logic [MAP_AW-1:0] ram_addr;
  logic [MAP_W-1:0]  ram_rdata;

  always_comb begin
    col         = ent_flipx ? ~cmd.chunk[1:0] : cmd.chunk[1:0];
    row         = ent_flipy ? ~cmd.chunk[4:2] : cmd.chunk[4:2];
    lookup_full = ADDR_W'({ent_tile, row, col});
    load_full   = ADDR_W'(map_address);
    ram_addr    = cmd.map_write ? load_full[MAP_AW-1:0] : lookup_full[MAP_AW-1:0];
  end

  zsce_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (cmd.map_write),
    .re    (cmd.issue),
    .addr  (ram_addr),
    .wdata (map_word),
    .rdata (ram_rdata)
  );

  // Read stage: chunk index that goes with the RAM data
  logic [CHUNK_W-1:0] rd_chunk;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_chunk <= cmd.chunk;
    end
  end

  // Chunk geometry: offsets and extents from small products
  logic [15:0] code;
  logic [9:0]  prod_x0;
  logic [9:0]  prod_x1;
  logic [10:0] prod_y0;
  logic [10:0] prod_y1;
  logic [7:0]  span_x;
  logic [7:0]  span_y;

  always_comb begin
    code    = ram_rdata & code_mask;
    prod_x0 = 10'(rd_chunk[1:0]) * 10'(ent_zoomx);
    prod_x1 = prod_x0 + 10'(ent_zoomx);
    prod_y0 = 11'(rd_chunk[4:2]) * 11'(ent_zoomy);
    prod_y1 = prod_y0 + 11'(ent_zoomy);
    span_x  = prod_x1[9:2] - prod_x0[9:2];
    span_y  = prod_y1[10:3] - prod_y0[10:3];
  end

  assign status.code_ok = (code != CODE_EMPTY);

  // Pending word: held until the next kept chunk or end of walk
  logic [15:0]        pend_code;
  logic [9:0]         pend_x;
  logic [9:0]         pend_y;
  logic [5:0]         pend_span_x;
  logic [4:0]         pend_span_y;
  logic [CHUNK_W-1:0] pend_chunk;

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_code   <= code;
      pend_x      <= ent_x + 10'(prod_x0[9:2]);
      pend_y      <= ent_y + 10'(prod_y0[10:3]);
      pend_span_x <= span_x[5:0];
      pend_span_y <= span_y[4:0];
      pend_chunk  <= rd_chunk;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tile_code       <= pend_code;
      palette         <= ent_palette;
      flip_horizontal <= ent_flipx;
      flip_vertical   <= ent_flipy;
      pos_x           <= $signed(pend_x);
      pos_y           <= $signed(pend_y);
      zoom_x          <= {pend_span_x, 12'd0};
      zoom_y          <= {pend_span_y, 13'd0};
      priority_res    <= ent_prio;
      chunk_index     <= pend_chunk;
      last            <= cmd.out_last;
    end
  end

endmodule

[src/zsce_ctrl.sv]
// ----------------------------------------------------------------------------
// zsce_ctrl
// Controller: input handshake, chunk walk counter, read/pending/output
// occupancy and flow control toward the output register.
// ----------------------------------------------------------------------------
module zsce_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  zsce_pkg::zsce_status_t status,
  output zsce_pkg::zsce_cmd_t    cmd
);

  import zsce_pkg::*;

  zsce_state_t      state;
  zsce_state_t      state_next;
  logic [CNT_W-1:0] issue_cnt;
  logic [CNT_W-1:0] issue_cnt_next;
  logic             rd_valid;
  logic             rd_valid_next;
  logic             pend_valid;
  logic             pend_valid_next;
  logic             out_valid_next;

  logic in_fire;
  logic out_free;
  logic rd_adv;
  logic walk_done;

  // State and occupancy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_cnt  <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      issue_cnt  <= issue_cnt_next;
      rd_valid   <= rd_valid_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    in_ready        = (state == ST_IDLE);
    in_fire         = in_valid && in_ready;
    out_free        = !out_valid || out_ready;
    rd_adv          = 1'b0;
    walk_done       = 1'b0;
    state_next      = state;
    issue_cnt_next  = issue_cnt;
    rd_valid_next   = rd_valid;
    pend_valid_next = pend_valid;
    cmd             = '0;
    cmd.chunk       = issue_cnt[CHUNK_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (opcode == OP_LOAD) begin
            cmd.map_write = 1'b1;
          end else if (!status.tile_zero) begin
            cmd.load_entry = 1'b1;
            issue_cnt_next = '0;
            state_next     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // read stage moves on unless a kept chunk finds both slots full
        rd_adv        = !rd_valid || !status.code_ok || !pend_valid || out_free;
        cmd.pend_load = rd_valid && status.code_ok && rd_adv;
        cmd.out_load  = cmd.pend_load && pend_valid;
        cmd.issue     = rd_adv && !issue_cnt[CNT_W-1];
        if (cmd.pend_load) begin
          pend_valid_next = 1'b1;
        end
        if (cmd.issue) begin
          issue_cnt_next = issue_cnt + CNT_W'(1);
          rd_valid_next  = 1'b1;
        end else if (rd_adv) begin
          rd_valid_next = 1'b0;
        end
        walk_done = rd_adv && issue_cnt[CNT_W-1];
        if (walk_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // final kept chunk goes out marked last
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_last    = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

`ifndef NO_ASSERTIONS
  // A word never overwrites an output word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output word overwritten while stalled");

  // Walk never issues more than one grid of reads
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !issue_cnt[CNT_W-1])
    else $error("chunk read issued past end of grid");

  // Nothing of a sprite is left in flight when a new item may enter
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_valid && !pend_valid))
    else $error("idle with chunk still in flight");

  // Read data is only live during a walk
  a_rd_walk: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_WALK))
    else $error("read stage valid outside walk");

  // A stalled read stage holds its chunk until the pending slot frees
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && rd_valid && !rd_adv) |=> (rd_valid && $stable(issue_cnt)))
    else $error("stalled read stage lost its chunk");
`endif

endmodule

[src/zoomed_sprite_chunk_expander_unit.sv]
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander_unit
// Top level: chunk map load and sprite entry expansion into zoomed chunks.
// ----------------------------------------------------------------------------
// A chunk is read from the map, held as the pending word and moved to the
// output register when the next kept chunk or the end of the walk is seen.
// A load or a tile-zero entry leaves the controller idle; an expanded entry holds
// off input until its 32 map reads through the single RAM port are issued and the final word marked last is released.
// Reset: controller idle, y_offset = 3, code mask = 0xffff; the chunk map is
// not cleared and is undefined until written.
module zoomed_sprite_chunk_expander_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [zsce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [15:0]                    map_address,
  input  logic [15:0]                    map_word,
  input  logic [15:0]                    entry_word0,
  input  logic [15:0]                    entry_word1,
  input  logic [15:0]                    entry_word2,
  input  logic [15:0]                    entry_word3,
  // output words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    tile_code,
  output logic [7:0]                     palette,
  output logic                           flip_horizontal,
  output logic                           flip_vertical,
  output logic signed [9:0]              pos_x,
  output logic signed [9:0]              pos_y,
  output logic [17:0]                    zoom_x,
  output logic [17:0]                    zoom_y,
  output logic                           priority_res,
  output logic [4:0]                     chunk_index,
  output logic                           last
);

  import zsce_pkg::*;

  zsce_cmd_t    cmd;
  zsce_status_t status;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  zsce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  zsce_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .map_address     (map_address),
    .map_word        (map_word),
    .entry_word0     (entry_word0),
    .entry_word1     (entry_word1),
    .entry_word2     (entry_word2),
    .entry_word3     (entry_word3),
    .tile_code       (tile_code),
    .palette         (palette),
    .flip_horizontal (flip_horizontal),
    .flip_vertical   (flip_vertical),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .zoom_x          (zoom_x),
    .zoom_y          (zoom_y),
    .priority_res    (priority_res),
    .chunk_index     (chunk_index),
    .last            (last)
  );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for zoomed_sprite_chunk_expander_unit. Loads chunk map
// blocks, walks a directed table of sprite entries (extremes, flips, coordinate
// wrap, empty chunks, tile zero), then runs random phases under several
// y_offset / code mask settings. Every accepted output word is compared field
// by field against an in-bench model of the chunk expansion.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zsce_pkg::*;

  localparam int NUM_BLOCKS    = MAP_DEPTH / CHUNKS_PER_SPRITE;
  localparam int SETTLE_CYCLES = 64;     // lets one full expansion finish
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 46;
  localparam int TIMEOUT_NS    = 5_000_000;

  // One output word
  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  pal;
    logic        flip_h;
    logic        flip_v;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [17:0] zx;
    logic [17:0] zy;
    logic        prio;
    logic [4:0]  idx;
    logic        is_last;
  } chunk_word_t;

  // One input word; has_want rows carry their single expected chunk word
  typedef struct packed {
    logic        op;
    logic [15:0] map_addr;
    logic [15:0] map_data;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic        has_want;
    chunk_word_t want;
  } in_word_t;

  // Directed table. Block 0 holds 0x0abc in word 0 and empty codes elsewhere;
  // block 0x7ff (map words 0xffe0..0xffff) holds random codes.
  localparam int N_DIRECTED = 20;
  localparam in_word_t DIRECTED [N_DIRECTED] = '{
    // after reset, tile 0x800 (aliases block 0), other fields zero: one chunk, y_offset 3 applied
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 1'b1,
      '{16'h0abc, 8'h00, 1'b0, 1'b0, 10'd0, 10'd3, 18'd0, 18'd0, 1'b0, 5'd0, 1'b1}},
    // all ones, both flips, max zoom: word 0 lands on chunk 31, x/y wrap
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h9800, 1'b1,
      '{16'h0abc, 8'hff, 1'b1, 1'b1, 10'd95, 10'd114, 18'h20000, 18'h20000,
        1'b1, 5'd31, 1'b1}},
    // tile zero, plain and with flips / unused bits set
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h1234, 16'h5678, 16'h9abc, 16'he000, 1'b0, '0},
    // empty code in the last map word
    '{OP_LOAD,   16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h07ff, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0003, 16'h9fff, 1'b0, '0},
    // x at the wrap limit and one past it
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h0140, 16'h0007, 16'h07ff, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h0141, 16'h0007, 16'h07ff, 1'b0, '0},
    // y + offset at the wrap limit and one past it
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h013d, 16'h0000, 16'h0007, 16'h07ff, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h013e, 16'h0000, 16'h0007, 16'h07ff, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h3e64, 16'h8064, 16'h5a1f, 16'h07ff, 1'b0, '0},
    // code zero, then empty out block 0 entirely
    '{OP_LOAD,   16'hffe0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_LOAD,   16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 1'b0, '0},
    '{OP_LOAD,   16'h001f, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h9000, 1'b0, '0},
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'hfe00, 16'h0000, 16'hff7f, 16'h07ff, 1'b0, '0},
    '{OP_LOAD,   16'hffff, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    // unused entry bits set
    '{OP_EXPAND, 16'h0000, 16'h0000, 16'h0155, 16'h3e55, 16'h0080, 16'h67ff, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 opcode = OP_LOAD;
  logic [15:0]          map_address = '0;
  logic [15:0]          map_word = '0;
  logic [15:0]          entry_word0 = '0;
  logic [15:0]          entry_word1 = '0;
  logic [15:0]          entry_word2 = '0;
  logic [15:0]          entry_word3 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          tile_code;
  logic [7:0]           palette;
  logic                 flip_horizontal;
  logic                 flip_vertical;
  logic signed [9:0]    pos_x;
  logic signed [9:0]    pos_y;
  logic [17:0]          zoom_x;
  logic [17:0]          zoom_y;
  logic                 priority_res;
  logic [4:0]           chunk_index;
  logic                 last;

  // Model state
  logic [15:0]  chunk_map_model [MAP_DEPTH];
  logic [4:0]   y_offset_q = Y_OFFSET_RESET;
  logic [15:0]  code_mask_q = CODE_MASK_RESET;
  chunk_word_t  chunk_expected [$];
  int           ready_blocks [$];
  bit           block_ready [NUM_BLOCKS];
  int           errors = 0;

  // Traffic shaping
  bit           tx_steady = 1'b0;
  logic         rx_steady = 1'b0;
  int           hold_orders = 0;
  int           hold_served = 0;
  int           hold_cnt = 0;

  zoomed_sprite_chunk_expander_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected chunk words for one sprite entry
  function automatic void predict_chunks(input logic [15:0] w0, w1, w2, w3);
    chunk_word_t       found [$];
    chunk_word_t       cw;
    logic [TILE_W-1:0] tile;
    logic [MAP_AW-1:0] addr;
    logic [15:0]       code;
    int                zoom_w, zoom_h, x0, y0, k, j, col, row, off_x, off_y;
    tile = w3[TILE_W-1:0];
    if (tile == '0) return;
    zoom_w = int'(w2[6:0]) + 1;
    zoom_h = int'(w0[15:9]) + 1;
    x0 = int'(w1[8:0]);
    y0 = int'(w0[8:0]) + int'($signed(y_offset_q));
    if (x0 > 320) x0 -= 512;
    if (y0 > 320) y0 -= 512;
    for (int c = 0; c < CHUNKS_PER_SPRITE; c++) begin
      k = c % 4;
      j = c / 4;
      col = w1[14] ? 3 - k : k;
      row = w3[15] ? 7 - j : j;
      addr = MAP_AW'(int'(tile) * 32 + row * 4 + col);
      code = chunk_map_model[addr] & code_mask_q;
      if (code == CODE_EMPTY) continue;
      off_x = k * zoom_w / 4;
      off_y = j * zoom_h / 8;
      cw.code = code;
      cw.pal = w2[15:8];
      cw.flip_h = w1[14];
      cw.flip_v = w3[15];
      cw.px = 10'(x0 + off_x);
      cw.py = 10'(y0 + off_y);
      cw.zx = 18'(((k + 1) * zoom_w / 4 - off_x) << 12);
      cw.zy = 18'(((j + 1) * zoom_h / 8 - off_y) << 13);
      cw.prio = w1[15];
      cw.idx = 5'(c);
      cw.is_last = 1'b0;
      found.push_back(cw);
    end
    if (found.size() != 0) found[found.size() - 1].is_last = 1'b1;
    foreach (found[i]) chunk_expected.push_back(found[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Output side: compare each accepted word with the oldest expectation
  task automatic check_chunk_word();
    chunk_word_t want;
    if (chunk_expected.size() == 0) begin
      errors++;
      $display("%0t: unexpected chunk word, expected none, got code %h chunk %0d",
               $time, tile_code, chunk_index);
      return;
    end
    want = chunk_expected.pop_front();
    check_field("tile_code", want.code, tile_code);
    check_field("palette", want.pal, palette);
    check_field("flip_horizontal", want.flip_h, flip_horizontal);
    check_field("flip_vertical", want.flip_v, flip_vertical);
    check_field("pos_x", want.px, $unsigned(pos_x));
    check_field("pos_y", want.py, $unsigned(pos_y));
    check_field("zoom_x", want.zx, zoom_x);
    check_field("zoom_y", want.zy, zoom_y);
    check_field("priority_res", want.prio, priority_res);
    check_field("chunk_index", want.idx, chunk_index);
    check_field("last", want.is_last, last);
  endtask

  always @(posedge clk)
    if (!rst && out_valid && out_ready) check_chunk_word();

  // Receiver: random stalls, steady stretches, and ordered long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_orders) begin
      hold_served <= hold_orders;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_steady || ($urandom_range(99) >= 20);
    end
  end

  // Drive one input word and update the model once it is taken
  task automatic send_word(input in_word_t item);
    in_word_t d;
    d = item;
    if (d.op == OP_LOAD) begin
      d.w0 = 16'($urandom);
      d.w1 = 16'($urandom);
      d.w2 = 16'($urandom);
      d.w3 = 16'($urandom);
    end else begin
      d.map_addr = 16'($urandom);
      d.map_data = 16'($urandom);
    end
    if (!tx_steady)
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    opcode <= d.op;
    map_address <= d.map_addr;
    map_word <= d.map_data;
    entry_word0 <= d.w0;
    entry_word1 <= d.w1;
    entry_word2 <= d.w2;
    entry_word3 <= d.w3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (d.op == OP_LOAD) chunk_map_model[MAP_AW'(d.map_addr)] = d.map_data;
    else if (d.has_want) chunk_expected.push_back(d.want);
    else predict_chunks(d.w0, d.w1, d.w2, d.w3);
  endtask

  // Sender pause: all expected words back, then let trailing work finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chunk_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_Y_OFFSET) y_offset_q = data[4:0];
    else code_mask_q = data;
  endtask

  task automatic set_config(input logic [4:0] y_off, input logic [15:0] mask);
    write_reg(CFG_Y_OFFSET, {11'($urandom), y_off});
    write_reg(CFG_CODE_MASK, mask);
    cfg_valid <= 1'b0;
  endtask

  // Write all 32 words of one map block; sparse leaves only word 0 non-empty
  task automatic fill_block(input int blk, input bit sparse);
    in_word_t w;
    for (int i = 0; i < CHUNKS_PER_SPRITE; i++) begin
      w = '0;
      w.op = OP_LOAD;
      w.map_addr = 16'(blk * CHUNKS_PER_SPRITE + i);
      if (sparse) w.map_data = (i == 0) ? 16'h0abc : CODE_EMPTY;
      else w.map_data = ($urandom_range(99) < 15) ? CODE_EMPTY : 16'($urandom);
      send_word(w);
    end
    if (!block_ready[blk]) ready_blocks.push_back(blk);
    block_ready[blk] = 1'b1;
  endtask

  // Mostly sprite entries on fully written blocks, plus map rewrites and noise
  task automatic run_random_phase(input int n_items, input bit fresh_block,
                                  input bit hold_out, input bit mid_pause);
    in_word_t          w;
    int                sent, blk, r;
    logic [TILE_W-1:0] tile;
    sent = 0;
    if (fresh_block) begin
      do blk = $urandom_range(1, NUM_BLOCKS - 2); while (block_ready[blk]);
      fill_block(blk, 1'b0);
      sent += CHUNKS_PER_SPRITE;
    end
    if (hold_out) hold_orders <= hold_orders + 1;
    while (sent < n_items) begin
      if (mid_pause && sent == n_items / 2) wait_drained();
      r = $urandom_range(99);
      blk = ready_blocks[$urandom_range(ready_blocks.size() - 1)];
      w = '0;
      w.w0 = 16'($urandom);
      w.w1 = 16'($urandom);
      w.w2 = 16'($urandom);
      w.map_data = ($urandom_range(3) == 0) ? CODE_EMPTY : 16'($urandom);
      if (r < 60) begin
        tile = TILE_W'(blk + NUM_BLOCKS * $urandom_range(0, 3));
        if (tile == '0) tile = TILE_W'(NUM_BLOCKS * $urandom_range(1, 3));
        w.op = OP_EXPAND;
        w.w3 = {3'($urandom), tile};
      end else if (r < 70) begin
        w.op = OP_EXPAND;
        w.w3 = {3'($urandom), 13'd0};
      end else if (r < 85) begin
        w.op = OP_LOAD;
        w.map_addr = 16'(blk * CHUNKS_PER_SPRITE + $urandom_range(CHUNKS_PER_SPRITE - 1));
      end else begin
        w.op = OP_LOAD;
        w.map_addr = 16'($urandom);
      end
      send_word(w);
      sent++;
    end
  endtask

  // Main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, two known blocks, then the table
    fill_block(0, 1'b1);
    fill_block(NUM_BLOCKS - 1, 1'b0);
    for (int i = 0; i < N_DIRECTED; i++) send_word(DIRECTED[i]);

    // lowest offset, full mask, fresh block, long output hold-off
    wait_drained();
    set_config(5'h10, 16'hffff);
    run_random_phase(PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

    // highest offset, zero mask so no chunk is skipped, no idling either side
    wait_drained();
    set_config(5'h0f, 16'h0000);
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
    tx_steady = 1'b0;
    rx_steady <= 1'b0;

    // zero offset, random mask, fresh block, another hold-off
    wait_drained();
    set_config(5'h00, 16'($urandom));
    run_random_phase(PHASE_ITEMS, 1'b1, 1'b1, 1'b0);

    // random offset, full mask, full drain midway
    wait_drained();
    set_config(5'($urandom), 16'hffff);
    run_random_phase(PHASE_ITEMS, 1'b0, 1'b0, 1'b1);

    wait_drained();
    if (errors == 0 && chunk_expected.size() == 0)
      $display("** zoomed_sprite_chunk_expander_unit: PASSED **");
    else
      $display("** zoomed_sprite_chunk_expander_unit: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("** zoomed_sprite_chunk_expander_unit: FAILED **");
    $finish;
  end

endmodule
